// ===== design/skrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared constants for the sorted key record table.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int RECORD_BITS_DEF = 32;

  localparam int KEY_BITS   = 16;
  localparam int FUNC_BITS  = 2;
  localparam int POS_BITS   = 5;
  localparam int REC_BITS   = 32;
  localparam int STAT_BITS  = 2;
  localparam int COUNT_BITS = 6;

  // one key above the largest 16-bit key marks the key space as used up
  localparam int NEXT_KEY_BITS = KEY_BITS + 1;

  localparam logic [KEY_BITS-1:0] FIRST_KEY_RST = 16'd1;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_UPDATE = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DELETE = 2'd3;

  localparam logic [STAT_BITS-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_MISSING = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_BADPOS  = 2'd3;

endpackage

// ===== design/skrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module skrt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/skrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrt_ctrl
// Operation sequencer: add, binary search for lookup/update, shift delete.
// ----------------------------------------------------------------------------
module skrt_ctrl import skrt_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int RECORD_BITS = RECORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [KEY_BITS-1:0]                    cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [FUNC_BITS-1:0]                   in_func,
  input  logic [KEY_BITS-1:0]                    in_key,
  input  logic [POS_BITS-1:0]                    in_position,
  input  logic [REC_BITS-1:0]                    in_record,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [STAT_BITS-1:0]                   out_status,
  output logic [KEY_BITS-1:0]                    out_key_out,
  output logic [REC_BITS-1:0]                    out_record_out,
  output logic [COUNT_BITS-1:0]                  out_count_out,
  output logic                                   ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0]            ram_wr_addr,
  output logic [KEY_BITS+RECORD_BITS-1:0]        ram_wr_data,
  output logic [$clog2(CAPACITY)-1:0]            ram_rd_addr,
  input  logic [KEY_BITS+RECORD_BITS-1:0]        ram_rd_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_PROBE  = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [FUNC_BITS-1:0]     func_r, func_nxt;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic [IW-1:0]            pos_r, pos_nxt;
  logic [RECORD_BITS-1:0]   rec_r, rec_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [NEXT_KEY_BITS-1:0] next_key_r, next_key_nxt;
  logic                     key_given_r, key_given_nxt;
  logic [CW-1:0]            lo_r, lo_nxt;
  logic [CW-1:0]            hi_r, hi_nxt;   // exclusive upper bound
  logic [IW-1:0]            mid_r, mid_nxt;
  logic [CW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [IW-1:0]            pend_addr_r, pend_addr_nxt;
  logic [STAT_BITS-1:0]     res_stat_r, res_stat_nxt;
  logic [KEY_BITS-1:0]      res_key_r, res_key_nxt;
  logic [RECORD_BITS-1:0]   res_rec_r, res_rec_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_BITS-1:0]     out_stat_r, out_stat_nxt;
  logic [KEY_BITS-1:0]      out_key_r, out_key_nxt;
  logic [REC_BITS-1:0]      out_rec_r, out_rec_nxt;
  logic [COUNT_BITS-1:0]    out_cnt_r, out_cnt_nxt;

  logic                     in_fire;
  logic                     slot_free;
  logic [CW:0]              mid_sum;
  logic [IW-1:0]            mid_calc;
  logic [KEY_BITS-1:0]      rd_key;
  logic [RECORD_BITS-1:0]   rd_rec;
  logic [63:0]              in_rec64;
  logic [63:0]              res_rec64;
  logic [31:0]              fill32;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_calc = mid_sum[IW:1];

  assign rd_key = ram_rd_data[RECORD_BITS +: KEY_BITS];
  assign rd_rec = ram_rd_data[RECORD_BITS-1:0];

  assign in_rec64  = 64'(in_record);
  assign res_rec64 = 64'(res_rec_r);
  assign fill32    = 32'(fill_r);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    rec_nxt       = rec_r;
    fill_nxt      = fill_r;
    next_key_nxt  = next_key_r;
    key_given_nxt = key_given_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    res_stat_nxt  = res_stat_r;
    res_key_nxt   = res_key_r;
    res_rec_nxt   = res_rec_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_stat_nxt  = out_stat_r;
    out_key_nxt   = out_key_r;
    out_rec_nxt   = out_rec_r;
    out_cnt_nxt   = out_cnt_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = pend_addr_r - IW'(1);
    ram_wr_data   = ram_rd_data;
    ram_rd_addr   = mid_calc;

    if (cfg_wr_en && !key_given_r) begin
      next_key_nxt = {1'b0, cfg_wr_data};
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt     = in_func;
          key_nxt      = in_key;
          pos_nxt      = IW'(32'(in_position));
          rec_nxt      = in_rec64[RECORD_BITS-1:0];
          res_stat_nxt = STAT_OK;
          res_key_nxt  = '0;
          res_rec_nxt  = '0;
          lo_nxt       = '0;
          hi_nxt       = fill_r;
          rd_ptr_nxt   = CW'(32'(in_position));
          pend_v_nxt   = 1'b0;
          case (in_func)
            FUNC_ADD: begin
              if ((fill32 >= 32'(CAPACITY)) || next_key_r[KEY_BITS]) begin
                res_stat_nxt = STAT_FULL;
                state_nxt    = ST_FINISH;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            FUNC_LOOKUP, FUNC_UPDATE: begin
              state_nxt = ST_PROBE;
            end
            default: begin
              if (32'(in_position) >= fill32) begin
                res_stat_nxt = STAT_BADPOS;
                state_nxt    = ST_FINISH;
              end else begin
                state_nxt = ST_SHIFT;
              end
            end
          endcase
        end
      end

      ST_ADD: begin
        ram_wr_en     = 1'b1;
        ram_wr_addr   = fill_r[IW-1:0];
        ram_wr_data   = {next_key_r[KEY_BITS-1:0], rec_r};
        res_key_nxt   = next_key_r[KEY_BITS-1:0];
        fill_nxt      = fill_r + CW'(1);
        next_key_nxt  = next_key_r + NEXT_KEY_BITS'(1);
        key_given_nxt = 1'b1;
        state_nxt     = ST_FINISH;
      end

      ST_PROBE: begin
        // read issued at mid; result compared next cycle
        if (lo_r >= hi_r) begin
          res_stat_nxt = STAT_MISSING;
          state_nxt    = ST_FINISH;
        end else begin
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end
      end

      ST_CMP: begin
        if (rd_key == key_r) begin
          res_key_nxt = key_r;
          if (func_r == FUNC_UPDATE) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = mid_r;
            ram_wr_data = {key_r, rec_r};
            res_rec_nxt = rec_r;
          end else begin
            res_rec_nxt = rd_rec;
          end
          state_nxt = ST_FINISH;
        end else if (rd_key < key_r) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = ST_PROBE;
        end else begin
          hi_nxt    = CW'(mid_r);
          state_nxt = ST_PROBE;
        end
      end

      ST_SHIFT: begin
        // reads run one entry ahead of the writes that move them down
        ram_rd_addr = rd_ptr_r[IW-1:0];
        if (pend_v_r) begin
          if (pend_addr_r == pos_r) begin
            res_key_nxt = rd_key;
          end else begin
            ram_wr_en = 1'b1;
          end
        end
        if (rd_ptr_r < fill_r) begin
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = rd_ptr_r[IW-1:0];
          rd_ptr_nxt    = rd_ptr_r + CW'(1);
        end else begin
          pend_v_nxt = 1'b0;
          if (!pend_v_r) begin
            fill_nxt  = fill_r - CW'(1);
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_key_nxt   = res_key_r;
          out_rec_nxt   = res_rec64[REC_BITS-1:0];
          out_cnt_nxt   = fill32[COUNT_BITS-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      next_key_r  <= {1'b0, FIRST_KEY_RST};
      key_given_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      next_key_r  <= next_key_nxt;
      key_given_r <= key_given_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    rec_r       <= rec_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_stat_r  <= res_stat_nxt;
    res_key_r   <= res_key_nxt;
    res_rec_r   <= res_rec_nxt;
    out_stat_r  <= out_stat_nxt;
    out_key_r   <= out_key_nxt;
    out_rec_r   <= out_rec_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_stat_r;
  assign out_key_out    = out_key_r;
  assign out_record_out = out_rec_r;
  assign out_count_out  = out_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill32 <= 32'(CAPACITY))
    else $error("fill count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer idle right after accept");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE || state_r == ST_CMP) |-> lo_r <= hi_r)
    else $error("search window inverted");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result beat without finish");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> fill_r != '0)
    else $error("delete shift on empty table");

endmodule

// ===== design/sorted_key_record_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_record_table_top
// Record table with self-assigned ascending keys, searched by binary search.
// ----------------------------------------------------------------------------
// Sequence: add goes through ADD to FINISH, a rejected add or delete straight
//   to FINISH; lookup and update alternate PROBE and CMP until a hit or an
//   empty window; delete runs SHIFT from position p to the fill count.
// Throughput: one op at a time; the next beat is taken once the result is
//   registered. Rate is set by the single read port of the entry RAM.
// Reset: count cleared, next key set to 1; RAM contents are not cleared.
module sorted_key_record_table_top import skrt_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int RECORD_BITS = RECORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [KEY_BITS-1:0]   cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_BITS-1:0]  in_func,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [POS_BITS-1:0]   in_position,
  input  logic [REC_BITS-1:0]   in_record,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_BITS-1:0]  out_status,
  output logic [KEY_BITS-1:0]   out_key_out,
  output logic [REC_BITS-1:0]   out_record_out,
  output logic [COUNT_BITS-1:0] out_count_out
);

  localparam int IW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + RECORD_BITS;

  logic          ram_wr_en;
  logic [IW-1:0] ram_wr_addr;
  logic [EW-1:0] ram_wr_data;
  logic [IW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;

  skrt_ctrl #(
    .CAPACITY    (CAPACITY),
    .RECORD_BITS (RECORD_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_position    (in_position),
    .in_record      (in_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_key_out    (out_key_out),
    .out_record_out (out_record_out),
    .out_count_out  (out_count_out),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data)
  );

  // entry layout: {key, record}
  skrt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
